// ===== rtl/rwr_pkg.sv =====
// shared types and constants of the receive window reorder block
package rwr_pkg;

  localparam int unsigned SEQ_W    = 31;
  localparam int unsigned WIN_W    = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_OOW    = 2'd3
  } status_e;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_INC = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic wr;
    logic clr;
    logic rd;
  } store_cmd_t;

endpackage

// ===== rtl/rwr_in_if.sv =====
// input item channel
interface rwr_in_if import rwr_pkg::*; #(
  parameter int unsigned REF_BITS = 16
);
  logic                valid;
  logic                ready;
  logic                op;
  logic [SEQ_W-1:0]    seq_num;
  logic                fin_mark;
  logic [REF_BITS-1:0] payload_ref;

  modport source (output valid, op, seq_num, fin_mark, payload_ref, input ready);
  modport sink   (input valid, op, seq_num, fin_mark, payload_ref, output ready);
endinterface

// ===== rtl/rwr_out_if.sv =====
// result item channel
interface rwr_out_if import rwr_pkg::*; #(
  parameter int unsigned REF_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    ack_num;
  logic [WIN_W-1:0]    adv_window;
  logic [STATUS_W-1:0] status;
  logic                read_valid;
  logic [SEQ_W-1:0]    read_seq;
  logic [REF_BITS-1:0] read_payload;
  logic                all_received;

  modport source (output valid, ack_num, adv_window, status, read_valid, read_seq,
                  read_payload, all_received, input ready);
  modport sink   (input valid, ack_num, adv_window, status, read_valid, read_seq,
                  read_payload, all_received, output ready);
endinterface

// ===== rtl/rwr_cfg_if.sv =====
// window size configuration write channel
interface rwr_cfg_if import rwr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/rwr_seq_alu.sv =====
// shared sequence number adder and subtractor
module rwr_seq_alu import rwr_pkg::*; (
  input  logic [SEQ_W-1:0] a_i,
  input  logic [SEQ_W-1:0] b_i,
  input  alu_op_e          op_i,
  output logic [SEQ_W-1:0] res_o,
  output logic             carry_o
);
  logic [SEQ_W:0] full;

  always_comb begin
    unique case (op_i)
      ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      ALU_INC: full = {1'b0, a_i} + (SEQ_W + 1)'(1);
      default: full = '0;
    endcase
  end

  assign res_o   = full[SEQ_W-1:0];
  assign carry_o = full[SEQ_W];
endmodule

// ===== rtl/rwr_slot_store.sv =====
// slot occupancy bitmap and payload reference memory
module rwr_slot_store import rwr_pkg::*; #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned REF_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  store_cmd_t               cmd_i,
  input  logic [$clog2(SLOTS)-1:0] wr_slot_i,
  input  logic [REF_BITS-1:0]      wr_data_i,
  input  logic [$clog2(SLOTS)-1:0] rd_slot_i,
  input  logic [$clog2(SLOTS)-1:0] q_slot_i,
  output logic                     q_hit_o,
  output logic [REF_BITS-1:0]      rd_data_o
);
  logic [SLOTS-1:0]    present_q;
  logic [REF_BITS-1:0] mem_q [SLOTS];
  logic [REF_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else begin
      if (cmd_i.wr) begin
        present_q[wr_slot_i] <= 1'b1;
      end
      if (cmd_i.clr) begin
        present_q[rd_slot_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[wr_slot_i] <= wr_data_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_slot_i];
    end
  end

  assign q_hit_o   = present_q[q_slot_i];
  assign rd_data_o = rd_data_q;
endmodule

// ===== rtl/rwr_ctrl.sv =====
// sequencer: window checks, ack advance walk and reads
module rwr_ctrl import rwr_pkg::*; #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned REF_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [WIN_W-1:0]         win_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [SEQ_W-1:0]         seq_i,
  input  logic                     fin_i,
  input  logic [REF_BITS-1:0]      ref_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SEQ_W-1:0]         ack_o,
  output logic [WIN_W-1:0]         adv_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     rvalid_o,
  output logic [SEQ_W-1:0]         rseq_o,
  output logic [REF_BITS-1:0]      rpay_o,
  output logic                     all_o,
  output store_cmd_t               cmd_o,
  output logic [$clog2(SLOTS)-1:0] wr_slot_o,
  output logic [REF_BITS-1:0]      wr_data_o,
  output logic [$clog2(SLOTS)-1:0] rd_slot_o,
  output logic [$clog2(SLOTS)-1:0] q_slot_o,
  input  logic                     q_hit_i,
  input  logic [REF_BITS-1:0]      rd_data_i
);
  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (CntW > WIN_W) ? CntW : WIN_W;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(SLOTS - 1);
  localparam logic [IdxW:0]   SlotsExt = (IdxW + 1)'(SLOTS);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ADV   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  function automatic logic [IdxW-1:0] step_slot(input logic [IdxW-1:0] s,
                                                input logic [SEQ_W-1:0] nxt);
    logic [IdxW-1:0] r;
    if (nxt == '0) begin
      r = '0;
    end else if (s == LastSlot) begin
      r = '0;
    end else begin
      r = s + IdxW'(1);
    end
    return r;
  endfunction

  logic [2:0]          state_q, state_d;
  logic                op_q, op_d;
  logic [SEQ_W-1:0]    seq_q, seq_d;
  logic                fin_q, fin_d;
  logic [REF_BITS-1:0] ref_q, ref_d;
  logic [SEQ_W-1:0]    off_q, off_d;
  logic                wrap_q, wrap_d;
  logic [SEQ_W-1:0]    ne_q, ne_d;
  logic [SEQ_W-1:0]    ntr_q, ntr_d;
  logic [IdxW-1:0]     ne_slot_q, ne_slot_d;
  logic [IdxW-1:0]     rd_slot_q, rd_slot_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SEQ_W-1:0]    fin_seq_q, fin_seq_d;
  logic                fin_seen_q, fin_seen_d;
  status_e             status_q, status_d;
  logic                rvalid_q, rvalid_d;
  logic [SEQ_W-1:0]    rseq_q, rseq_d;
  logic [REF_BITS-1:0] rpay_q, rpay_d;

  logic                out_valid_q, out_valid_d;
  logic [SEQ_W-1:0]    out_ack_q, out_ack_d;
  logic [WIN_W-1:0]    out_adv_q, out_adv_d;
  status_e             out_status_q, out_status_d;
  logic                out_rvalid_q, out_rvalid_d;
  logic [SEQ_W-1:0]    out_rseq_q, out_rseq_d;
  logic [REF_BITS-1:0] out_rpay_q, out_rpay_d;
  logic                out_all_q, out_all_d;

  logic [SEQ_W-1:0]    alu_a, alu_b, alu_res;
  alu_op_e             alu_op;
  logic                alu_carry;

  logic [CmpW-1:0]     cnt_x, win_x;
  logic [WIN_W-1:0]    adv_now;
  logic [IdxW:0]       slot_sum, slot_red;
  logic [IdxW-1:0]     chk_slot;
  logic [SEQ_W-1:0]    fin_next;

  rwr_seq_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .op_i    (alu_op),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  assign cnt_x    = CmpW'(cnt_q);
  assign win_x    = CmpW'(win_i);
  assign adv_now  = (cnt_x >= win_x) ? '0 : WIN_W'(win_x - cnt_x);
  assign slot_sum = {1'b0, rd_slot_q} + {1'b0, off_q[IdxW-1:0]};
  assign slot_red = slot_sum - SlotsExt;
  assign chk_slot = wrap_q ? seq_q[IdxW-1:0] :
                    (slot_sum >= SlotsExt) ? slot_red[IdxW-1:0] : slot_sum[IdxW-1:0];
  assign fin_next = fin_seq_q + SEQ_W'(1);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    seq_d        = seq_q;
    fin_d        = fin_q;
    ref_d        = ref_q;
    off_d        = off_q;
    wrap_d       = wrap_q;
    ne_d         = ne_q;
    ntr_d        = ntr_q;
    ne_slot_d    = ne_slot_q;
    rd_slot_d    = rd_slot_q;
    cnt_d        = cnt_q;
    fin_seq_d    = fin_seq_q;
    fin_seen_d   = fin_seen_q;
    status_d     = status_q;
    rvalid_d     = rvalid_q;
    rseq_d       = rseq_q;
    rpay_d       = rpay_q;
    out_valid_d  = out_valid_q;
    out_ack_d    = out_ack_q;
    out_adv_d    = out_adv_q;
    out_status_d = out_status_q;
    out_rvalid_d = out_rvalid_q;
    out_rseq_d   = out_rseq_q;
    out_rpay_d   = out_rpay_q;
    out_all_d    = out_all_q;
    alu_a        = ne_q;
    alu_b        = ntr_q;
    alu_op       = ALU_INC;
    cmd_o        = '0;
    q_slot_o     = ne_slot_q;
    in_ready_o   = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_i;
          seq_d    = seq_i;
          fin_d    = fin_i;
          ref_d    = ref_i;
          status_d = ST_STORED;
          rvalid_d = 1'b0;
          rseq_d   = '0;
          rpay_d   = '0;
          state_d  = S_CALC;
        end
      end
      S_CALC: begin
        alu_a   = seq_q;
        alu_b   = ntr_q;
        alu_op  = ALU_SUB;
        off_d   = alu_res;
        wrap_d  = alu_carry;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (op_q == OP_READ) begin
          q_slot_o = rd_slot_q;
          alu_a    = ntr_q;
          alu_op   = ALU_INC;
          if (cnt_q != '0 && q_hit_i) begin
            cmd_o.rd  = 1'b1;
            cmd_o.clr = 1'b1;
            rvalid_d  = 1'b1;
            rseq_d    = ntr_q;
            ntr_d     = alu_res;
            rd_slot_d = step_slot(rd_slot_q, alu_res);
            cnt_d     = cnt_q - CntW'(1);
            state_d   = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          q_slot_o = chk_slot;
          state_d  = S_DONE;
          if (adv_now == '0) begin
            status_d = ST_FULL;
          end else if (off_q[SEQ_W-1] || off_q < SEQ_W'(cnt_q)) begin
            status_d = ST_DUP;
          end else if (off_q >= SEQ_W'(win_i)) begin
            status_d = ST_OOW;
          end else if (q_hit_i) begin
            status_d = ST_DUP;
          end else begin
            cmd_o.wr = 1'b1;
            status_d = ST_STORED;
            if (fin_q) begin
              fin_seq_d  = seq_q;
              fin_seen_d = 1'b1;
            end
            state_d = S_ADV;
          end
        end
      end
      S_ADV: begin
        q_slot_o = ne_slot_q;
        alu_a    = ne_q;
        alu_op   = ALU_INC;
        if (cnt_q < SlotsCnt && q_hit_i) begin
          ne_d      = alu_res;
          ne_slot_d = step_slot(ne_slot_q, alu_res);
          cnt_d     = cnt_q + CntW'(1);
        end else begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        rpay_d  = rd_data_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_ack_d    = ne_q;
          out_adv_d    = (status_q == ST_FULL) ? '0 : adv_now;
          out_status_d = status_q;
          out_rvalid_d = rvalid_q;
          out_rseq_d   = rseq_q;
          out_rpay_d   = rpay_q;
          out_all_d    = fin_seen_q && (ne_q == fin_next);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ne_q        <= SEQ_W'(1);
      ntr_q       <= SEQ_W'(1);
      ne_slot_q   <= IdxW'(1);
      rd_slot_q   <= IdxW'(1);
      cnt_q       <= '0;
      fin_seq_q   <= '0;
      fin_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ne_q        <= ne_d;
      ntr_q       <= ntr_d;
      ne_slot_q   <= ne_slot_d;
      rd_slot_q   <= rd_slot_d;
      cnt_q       <= cnt_d;
      fin_seq_q   <= fin_seq_d;
      fin_seen_q  <= fin_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    seq_q        <= seq_d;
    fin_q        <= fin_d;
    ref_q        <= ref_d;
    off_q        <= off_d;
    wrap_q       <= wrap_d;
    status_q     <= status_d;
    rvalid_q     <= rvalid_d;
    rseq_q       <= rseq_d;
    rpay_q       <= rpay_d;
    out_ack_q    <= out_ack_d;
    out_adv_q    <= out_adv_d;
    out_status_q <= out_status_d;
    out_rvalid_q <= out_rvalid_d;
    out_rseq_q   <= out_rseq_d;
    out_rpay_q   <= out_rpay_d;
    out_all_q    <= out_all_d;
  end

  assign wr_slot_o   = chk_slot;
  assign wr_data_o   = ref_q;
  assign rd_slot_o   = rd_slot_q;
  assign out_valid_o = out_valid_q;
  assign ack_o       = out_ack_q;
  assign adv_o       = out_adv_q;
  assign status_o    = out_status_q;
  assign rvalid_o    = out_rvalid_q;
  assign rseq_o      = out_rseq_q;
  assign rpay_o      = out_rpay_q;
  assign all_o       = out_all_q;
endmodule

// ===== rtl/receive_window_reorder_top.sv =====
// receive window reorder top level
// Receive side of a sliding-window transport with reordering.
// in_i carries one item per transfer: op 0 delivers a packet (seq_num,
// fin_mark, payload_ref), op 1 pops the next in-order packet.
// out_o returns one result per item: cumulative ack, advertised
// window, status, read fields and the all-received flag.
// cfg_i writes the window size; 0 acts as 1, values above SLOTS clamp.
// Write it only while no item is in flight.
// Path from input transfer to result valid: every item passes CALC and
// CHECK; a read that hands out a packet then READ, a stored packet the
// ack walk ADV, which steps over up to SLOTS packets and tests one slot
// bit per cycle through the shared adder; then DONE loads the result.
// in_i.ready is high only while the sequencer is idle; one item at a time,
// so the next item is taken at the earliest in the cycle after a result loads.
// The result sits in an output register; a stall on out_o holds it there
// and the next item is taken and worked meanwhile, then waits to unload.
// Reset empties all slots, sets ack and read point to 1, window to the smaller of SLOTS and 64.
module receive_window_reorder_top import rwr_pkg::*; #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned REF_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwr_in_if.sink     in_i,
  rwr_out_if.source  out_o,
  rwr_cfg_if.sink    cfg_i
);
  localparam int unsigned IdxW   = $clog2(SLOTS);
  localparam int unsigned WinRst = (SLOTS < 64) ? SLOTS : 64;

  logic [WIN_W-1:0]    win_q, win_d;
  store_cmd_t          cmd;
  logic [IdxW-1:0]     wr_slot, rd_slot, q_slot;
  logic [REF_BITS-1:0] wr_data, rd_data;
  logic                q_hit;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    win_d = win_q;
    if (cfg_i.valid) begin
      if (cfg_i.data == '0) begin
        win_d = WIN_W'(1);
      end else if (32'(cfg_i.data) > SLOTS) begin
        win_d = WIN_W'(SLOTS);
      end else begin
        win_d = cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_W'(WinRst);
    end else begin
      win_q <= win_d;
    end
  end

  rwr_ctrl #(
    .SLOTS    (SLOTS),
    .REF_BITS (REF_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .op_i        (in_i.op),
    .seq_i       (in_i.seq_num),
    .fin_i       (in_i.fin_mark),
    .ref_i       (in_i.payload_ref),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ack_o       (out_o.ack_num),
    .adv_o       (out_o.adv_window),
    .status_o    (out_o.status),
    .rvalid_o    (out_o.read_valid),
    .rseq_o      (out_o.read_seq),
    .rpay_o      (out_o.read_payload),
    .all_o       (out_o.all_received),
    .cmd_o       (cmd),
    .wr_slot_o   (wr_slot),
    .wr_data_o   (wr_data),
    .rd_slot_o   (rd_slot),
    .q_slot_o    (q_slot),
    .q_hit_i     (q_hit),
    .rd_data_i   (rd_data)
  );

  rwr_slot_store #(
    .SLOTS    (SLOTS),
    .REF_BITS (REF_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .wr_slot_i (wr_slot),
    .wr_data_i (wr_data),
    .rd_slot_i (rd_slot),
    .q_slot_i  (q_slot),
    .q_hit_o   (q_hit),
    .rd_data_o (rd_data)
  );

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  a_adv_le_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.adv_window <= win_q)
    else $error("advertised window above window size");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_FULL |-> out_o.adv_window == '0)
    else $error("window full result with nonzero window");

  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.read_valid |-> out_o.status == ST_STORED)
    else $error("read result with nonzero status");
endmodule

// ===== sim/receive_window_reorder_top_test.sv =====
// testbench for receive_window_reorder_top: random and directed packets, reads and window writes
`timescale 1ns / 1ps

module receive_window_reorder_top_test;
  import rwr_pkg::*;

  localparam int unsigned SLOTS    = 64;
  localparam int unsigned REF_BITS = 16;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam logic [SEQ_W-1:0] HALF_SEQ = 31'h4000_0000;

  typedef enum logic [1:0] {
    JOB_ITEM,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_e;

  typedef struct packed {
    job_kind_e           kind;
    op_e                 op;
    logic [SEQ_W-1:0]    seq;
    logic                fin;
    logic [REF_BITS-1:0] pref;
    logic [WIN_W-1:0]    wsize;
  } job_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    ack;
    logic [WIN_W-1:0]    adv;
    status_e             status;
    logic                rd_ok;
    logic [SEQ_W-1:0]    rd_seq;
    logic [REF_BITS-1:0] rd_ref;
    logic                done;
  } reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid  = 1'b0;
  op_e                 in_op     = OP_RECV;
  logic [SEQ_W-1:0]    in_seq    = '0;
  logic                in_fin    = 1'b0;
  logic [REF_BITS-1:0] in_pref   = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [WIN_W-1:0]    cfg_data  = '0;

  rwr_in_if  #(.REF_BITS(REF_BITS)) in_if ();
  rwr_out_if #(.REF_BITS(REF_BITS)) out_if ();
  rwr_cfg_if cfg_if ();

  assign in_if.valid       = in_valid;
  assign in_if.op          = in_op;
  assign in_if.seq_num     = in_seq;
  assign in_if.fin_mark    = in_fin;
  assign in_if.payload_ref = in_pref;
  assign out_if.ready      = out_ready;
  assign cfg_if.valid      = cfg_valid;
  assign cfg_if.data       = cfg_data;

  receive_window_reorder_top #(
    .SLOTS    (SLOTS),
    .REF_BITS (REF_BITS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted receiver state
  logic [SLOTS-1:0]    held = '0;
  logic [REF_BITS-1:0] held_ref [SLOTS];
  logic [SEQ_W-1:0]    ack_ptr  = 31'd1;
  logic [SEQ_W-1:0]    read_ptr = 31'd1;
  logic [SEQ_W-1:0]    fin_at   = '0;
  logic                fin_flag = 1'b0;
  logic [WIN_W-1:0]    win      = 7'd64;

  job_t   tx_jobs [$];
  reply_t pending_replies [$];
  job_t   on_bus;

  int unsigned items_sent = 0;
  int unsigned windows_written = 0;
  int unsigned errors = 0;
  int unsigned settle_cnt = 0;
  int unsigned n_stored = 0, n_dup = 0, n_full = 0, n_oow = 0;
  int unsigned n_handout = 0, n_dry_read = 0, n_done = 0;

  function automatic logic [SEQ_W-1:0] in_order();
    return ack_ptr - read_ptr;
  endfunction

  function automatic logic [WIN_W-1:0] open_window();
    logic [SEQ_W-1:0] d;
    d = in_order();
    return (d >= win) ? '0 : win - d[WIN_W-1:0];
  endfunction

  function automatic reply_t rx_window_step(input job_t it);
    reply_t           r;
    logic [SEQ_W-1:0] off;
    logic [SLOT_W-1:0] s;
    r = '0;
    r.status = ST_STORED;
    if (it.op == OP_READ) begin
      s = read_ptr[SLOT_W-1:0];
      if (in_order() != 0 && held[s]) begin
        r.rd_ok  = 1'b1;
        r.rd_seq = read_ptr;
        r.rd_ref = held_ref[s];
        held[s]  = 1'b0;
        read_ptr = read_ptr + 31'd1;
        n_handout++;
      end else begin
        n_dry_read++;
      end
    end else if (open_window() == 0) begin
      r.status = ST_FULL;
      n_full++;
    end else begin
      off = it.seq - read_ptr;
      s   = it.seq[SLOT_W-1:0];
      if (off >= HALF_SEQ || off < in_order()) begin
        r.status = ST_DUP;
        n_dup++;
      end else if (off >= win) begin
        r.status = ST_OOW;
        n_oow++;
      end else if (held[s]) begin
        r.status = ST_DUP;
        n_dup++;
      end else begin
        held[s]     = 1'b1;
        held_ref[s] = it.pref;
        n_stored++;
        if (it.fin) begin
          fin_at   = it.seq;
          fin_flag = 1'b1;
        end
        while (in_order() < SLOTS && held[ack_ptr[SLOT_W-1:0]])
          ack_ptr = ack_ptr + 31'd1;
      end
    end
    r.ack  = ack_ptr;
    r.adv  = (r.status == ST_FULL) ? '0 : open_window();
    r.done = fin_flag && (ack_ptr == fin_at + 31'd1);
    if (r.done) n_done++;
    return r;
  endfunction

  function automatic int unsigned stall_pct();
    return (items_sent >= 500 && items_sent < 720) ? 0 : 36;
  endfunction

  function automatic void push_pkt(input logic [SEQ_W-1:0] s, input logic f,
                                   input logic [REF_BITS-1:0] p);
    job_t j;
    j      = '0;
    j.kind = JOB_ITEM;
    j.op   = OP_RECV;
    j.seq  = s;
    j.fin  = f;
    j.pref = p;
    tx_jobs.push_back(j);
  endfunction

  function automatic void push_read();
    job_t j;
    j      = '0;
    j.kind = JOB_ITEM;
    j.op   = OP_READ;
    tx_jobs.push_back(j);
  endfunction

  function automatic void push_job(input job_kind_e k, input logic [WIN_W-1:0] w);
    job_t j;
    j       = '0;
    j.kind  = k;
    j.wsize = w;
    tx_jobs.push_back(j);
  endfunction

  function automatic job_t next_random_item();
    job_t        j;
    int unsigned r;
    j      = '0;
    j.kind = JOB_ITEM;
    j.op   = OP_RECV;
    j.fin  = ($urandom_range(99) < 6);
    j.pref = REF_BITS'($urandom);
    r      = $urandom_range(99);
    if (r < 33) begin
      j.op  = OP_READ;
      j.seq = SEQ_W'($urandom);
      j.fin = $urandom_range(1);
    end else if (r < 78) begin
      j.seq = read_ptr + SEQ_W'($urandom_range(0, win));
    end else if (r < 88) begin
      j.seq = ack_ptr;
    end else if (r < 93) begin
      j.seq = read_ptr + SEQ_W'(win) + SEQ_W'($urandom_range(0, 200));
    end else if (r < 97) begin
      j.seq = read_ptr - SEQ_W'($urandom_range(1, 40));
    end else begin
      j.seq = SEQ_W'($urandom);
    end
    return j;
  endfunction

  always @(posedge clk_i) begin : drive_items
    logic n_in_valid;
    logic n_cfg_valid;
    job_t nxt;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_valid && in_if.ready) begin
        pending_replies.push_back(rx_window_step(on_bus));
        items_sent++;
      end
      if (cfg_valid && cfg_if.ready) begin
        win = (cfg_data == 0) ? 7'd1 : (cfg_data > SLOTS) ? WIN_W'(SLOTS) : cfg_data;
        windows_written++;
      end
      n_in_valid  = in_valid && !in_if.ready;
      n_cfg_valid = cfg_valid && !cfg_if.ready;
      if (!n_in_valid && !n_cfg_valid && tx_jobs.size() != 0) begin
        if (tx_jobs[0].kind == JOB_ITEM) begin
          if ($urandom_range(99) >= stall_pct()) begin
            nxt        = tx_jobs.pop_front();
            on_bus     = nxt;
            n_in_valid = 1'b1;
            in_op   <= nxt.op;
            in_seq  <= nxt.seq;
            in_fin  <= nxt.fin;
            in_pref <= nxt.pref;
          end
        end else if (pending_replies.size() == 0) begin
          if (settle_cnt < 8) begin
            settle_cnt++;
          end else begin
            settle_cnt = 0;
            nxt = tx_jobs.pop_front();
            if (nxt.kind == JOB_CFG) begin
              n_cfg_valid = 1'b1;
              cfg_data <= nxt.wsize;
            end
          end
        end else begin
          settle_cnt = 0;
        end
      end
      in_valid  <= n_in_valid;
      cfg_valid <= n_cfg_valid;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_if.valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, got ack %0d status %0d",
                   $time, out_if.ack_num, out_if.status);
        end else begin
          want = pending_replies.pop_front();
          check_field("ack_num", 32'(want.ack), 32'(out_if.ack_num));
          check_field("adv_window", 32'(want.adv), 32'(out_if.adv_window));
          check_field("status", 32'(want.status), 32'(out_if.status));
          check_field("read_valid", 32'(want.rd_ok), 32'(out_if.read_valid));
          check_field("read_seq", 32'(want.rd_seq), 32'(out_if.read_seq));
          check_field("read_payload", 32'(want.rd_ref), 32'(out_if.read_payload));
          check_field("all_received", 32'(want.done), 32'(out_if.all_received));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct());
    end
  end

  initial begin
    logic [WIN_W-1:0] phase_win [8];
    phase_win = '{7'd127, 7'd3, 7'd40, 7'd1, 7'd65, 7'd64, 7'd0, 7'd0};
    phase_win[7] = WIN_W'($urandom_range(0, 127));

    // reset window, in-order, holes, fin, far and behind packets
    push_read();
    push_pkt(31'd1, 1'b0, 16'hffff);
    push_pkt(31'd1, 1'b0, 16'h0001);
    push_pkt(31'd3, 1'b1, 16'h0000);
    push_pkt(31'd0, 1'b0, 16'h0002);
    push_pkt(31'd65, 1'b0, 16'h0003);
    push_pkt(31'd64, 1'b0, 16'h8001);
    push_pkt(31'd2, 1'b0, 16'h1234);
    push_pkt(31'h4000_0000, 1'b0, 16'h0004);
    push_pkt(31'h4000_0001, 1'b1, 16'h0005);
    push_pkt(31'h7fff_ffff, 1'b1, 16'hffff);
    push_read();
    push_read();
    push_read();
    push_read();
    push_pkt(31'd5, 1'b1, 16'h5555);
    push_pkt(31'd4, 1'b1, 16'haaaa);
    // window shrunk below held packets, then window full
    push_job(JOB_CFG, 7'd0);
    push_pkt(31'd6, 1'b0, 16'h0006);
    push_read();
    push_read();
    push_pkt(31'd7, 1'b0, 16'h0007);
    push_pkt(31'd6, 1'b0, 16'h0106);
    push_pkt(31'd6, 1'b0, 16'h0206);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 8; p++) begin
      push_job(JOB_CFG, phase_win[p]);
      for (int k = 0; k < 172; k++) begin
        while (tx_jobs.size() >= 3) @(negedge clk_i);
        tx_jobs.push_back(next_random_item());
        if (p == 2 && k == 80) push_job(JOB_DRAIN, '0);
      end
    end

    while (tx_jobs.size() != 0 || in_valid || pending_replies.size() != 0)
      @(negedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d items over %0d window writes: %0d stored, %0d duplicate, %0d full, %0d out of window",
             items_sent, windows_written, n_stored, n_dup, n_full, n_oow);
    $display("reads: %0d handed out, %0d found nothing; all-received reported on %0d results",
             n_handout, n_dry_read, n_done);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== receive_window_reorder_top.f =====
rtl/rwr_pkg.sv
rtl/rwr_in_if.sv
rtl/rwr_out_if.sv
rtl/rwr_cfg_if.sv
rtl/rwr_seq_alu.sv
rtl/rwr_slot_store.sv
rtl/rwr_ctrl.sv
rtl/receive_window_reorder_top.sv
sim/receive_window_reorder_top_test.sv
